// ----- hw/rtl/tse_pkg.sv -----
// Shared types, constants and the reciprocal factorial table of the Taylor series evaluator.
package tse_pkg;

    // Sizes
    localparam int MAX_ORDER = 7;
    localparam int DEPTH     = MAX_ORDER + 1;
    localparam int IDX_W     = 3;
    localparam int DATA_W    = 32;
    localparam int DELTA_W   = DATA_W + 1;
    localparam int TERM_W    = 46;
    localparam int PART_W    = TERM_W / 2;
    localparam int PP_W      = PART_W + DATA_W;
    localparam int PROD_W    = TERM_W + DATA_W;
    localparam int MUL_W     = 2 * DATA_W;
    localparam int SUM_W     = TERM_W + 4;
    localparam int SDATA_W   = 72;
    localparam int PROD_LIM_B = 62;
    localparam int FRAC_B    = 16;

    // Largest term magnitude
    localparam logic [TERM_W-1:0] TERM_LIM = {TERM_W{1'b1}};

    // Item kinds carried in s_tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Input word layout
    localparam int IDX_LSB   = 0;
    localparam int COEFF_LSB = IDX_LSB + IDX_W;
    localparam int POINT_LSB = COEFF_LSB + DATA_W;

    typedef logic [IDX_W-1:0] idx_t;

    // Datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_LOAD,
        CMD_COEF,
        CMD_MLO,
        CMD_MHI,
        CMD_NORM,
        CMD_ACC,
        CMD_FIN
    } dp_cmd_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic term_done;
        logic last_term;
    } dp_status_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COEF,
        ST_MLO,
        ST_MHI,
        ST_NORM,
        ST_FIN
    } ctl_state_t;

    // round(2^32 / i!) as Q0.32; orders 0 and 1 are 1.0, hold zero here and bypass the multiplier
    function automatic logic [DATA_W-1:0] recip_fact(input idx_t i);
        logic [DATA_W-1:0] r;
        begin
            unique case (i)
                3'd0:    r = 32'd0;
                3'd1:    r = 32'd0;
                3'd2:    r = 32'd2147483648;
                3'd3:    r = 32'd715827883;
                3'd4:    r = 32'd178956971;
                3'd5:    r = 32'd35791394;
                3'd6:    r = 32'd5965232;
                3'd7:    r = 32'd852176;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- hw/rtl/tse_ctrl.sv -----
// Controller state machine of the Taylor series evaluator: sequences term steps and the output word.
module tse_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tuser,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  tse_pkg::dp_status_t  status,
    output tse_pkg::dp_cmd_t     cmd
);
    import tse_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    // State and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        cmd           = CMD_NONE;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = out_free;
                if (s_tvalid && out_free) begin
                    if (s_tuser == OP_EVAL) begin
                        cmd        = CMD_LOAD;
                        state_next = ST_COEF;
                    end else begin
                        cmd           = CMD_WRITE;
                        m_tvalid_next = 1'b1;
                    end
                end
            end
            ST_COEF: begin
                cmd        = CMD_COEF;
                state_next = ST_MLO;
            end
            ST_MLO: begin
                // term finished: add it and move to the next order, or to the output after the last
                if (status.term_done) begin
                    cmd        = CMD_ACC;
                    state_next = status.last_term ? ST_FIN : ST_COEF;
                end else begin
                    cmd        = CMD_MLO;
                    state_next = ST_MHI;
                end
            end
            ST_MHI: begin
                cmd        = CMD_MHI;
                state_next = ST_NORM;
            end
            ST_NORM: begin
                cmd        = CMD_NORM;
                state_next = ST_MLO;
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd           = CMD_FIN;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/tse_datapath.sv -----
// Datapath of the Taylor series evaluator: derivative store, shared multiplier, term and sum registers.
module tse_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tse_pkg::dp_cmd_t              cmd,
    input  logic [tse_pkg::SDATA_W-1:0]   in_data,
    input  logic                          cfg_wr_en,
    input  logic [tse_pkg::DATA_W-1:0]    cfg_wr_data,
    output tse_pkg::dp_status_t           status,
    output logic [tse_pkg::DATA_W-1:0]    out_value,
    output logic                          out_status
);
    import tse_pkg::*;

    localparam logic signed [SUM_W-1:0] SUM_MAX =
        {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN =
        {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    logic [DATA_W-1:0]        ep_reg;
    logic [DATA_W-1:0]        store_reg [DEPTH];
    logic [DATA_W-1:0]        dmag_reg;
    logic                     dneg_reg;
    idx_t                     idx_reg;
    idx_t                     steps_reg;
    logic [TERM_W-1:0]        tmag_reg;
    logic                     tneg_reg;
    logic [PP_W-1:0]          pp_reg;
    logic [PP_W-1:0]          hp_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     sat_reg;
    logic [DATA_W-1:0]        out_value_reg;
    logic                     out_status_reg;

    idx_t                     wr_idx;
    logic [DATA_W-1:0]        wr_value;
    logic [DATA_W-1:0]        point;
    logic signed [DELTA_W-1:0] delta;
    logic [DELTA_W-1:0]       delta_mag;
    logic [DATA_W-1:0]        d_cur;
    logic                     d_neg;
    logic [DATA_W-1:0]        d_mag;
    logic [DATA_W-1:0]        coef;
    logic [DATA_W-1:0]        mul_a;
    logic [DATA_W-1:0]        mul_b;
    logic [MUL_W-1:0]         mul_p;
    logic [PROD_W-1:0]        full_prod;
    logic                     over;
    logic [TERM_W-1:0]        new_mag;
    logic signed [SUM_W-1:0]  term_ext;
    logic signed [SUM_W-1:0]  term_s;
    logic                     clip_hi;
    logic                     clip_lo;

    // Input word fields
    assign wr_idx   = in_data[IDX_LSB +: IDX_W];
    assign wr_value = in_data[COEFF_LSB +: DATA_W];
    assign point    = in_data[POINT_LSB +: DATA_W];

    // x - a, exact in 33 bits, split into sign and magnitude
    assign delta     = $signed({point[DATA_W-1], point}) - $signed({ep_reg[DATA_W-1], ep_reg});
    assign delta_mag = delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);

    // Current derivative as sign and magnitude
    assign d_cur = store_reg[idx_reg];
    assign d_neg = d_cur[DATA_W-1];
    assign d_mag = d_neg ? (~d_cur + DATA_W'(1)) : d_cur;

    // Shared 32x32 multiplier: coefficient scaling or one half of a term step
    always_comb begin
        unique case (cmd)
            CMD_MLO: begin
                mul_a = {{(DATA_W-PART_W){1'b0}}, tmag_reg[PART_W-1:0]};
                mul_b = dmag_reg;
            end
            CMD_MHI: begin
                mul_a = {{(DATA_W-PART_W){1'b0}}, tmag_reg[TERM_W-1:PART_W]};
                mul_b = dmag_reg;
            end
            default: begin
                mul_a = d_mag;
                mul_b = recip_fact(idx_reg);
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Orders 0 and 1 have reciprocal 1.0
    assign coef = (idx_reg < idx_t'(2)) ? d_mag : mul_p[MUL_W-1:DATA_W];

    // Term step: recombine halves, clamp, drop fraction bits
    assign full_prod = {hp_reg, {PART_W{1'b0}}} + {{(PROD_W-PP_W){1'b0}}, pp_reg};
    assign over      = |full_prod[PROD_W-1:PROD_LIM_B];
    assign new_mag   = over ? TERM_LIM : full_prod[FRAC_B +: TERM_W];

    // Signed term for the running sum
    assign term_ext = {{(SUM_W-TERM_W){1'b0}}, tmag_reg};
    assign term_s   = tneg_reg ? -term_ext : term_ext;

    // Final saturation to 32 bits
    assign clip_hi = sum_reg > SUM_MAX;
    assign clip_lo = sum_reg < SUM_MIN;

    // Expansion point and derivative store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ep_reg <= '0;
            for (int i = 0; i < DEPTH; i++) begin
                store_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                ep_reg <= cfg_wr_data;
            end
            if (cmd == CMD_WRITE) begin
                store_reg[wr_idx] <= wr_value;
            end
        end
    end

    // Evaluation registers
    always_ff @(posedge aclk) begin
        unique case (cmd)
            CMD_WRITE: begin
                out_value_reg  <= '0;
                out_status_reg <= 1'b0;
            end
            CMD_LOAD: begin
                dneg_reg <= delta[DELTA_W-1];
                dmag_reg <= delta_mag[DATA_W-1:0];
                idx_reg  <= '0;
                sum_reg  <= '0;
                sat_reg  <= 1'b0;
            end
            CMD_COEF: begin
                tmag_reg  <= {{(TERM_W-DATA_W){1'b0}}, coef};
                tneg_reg  <= d_neg && (coef != '0);
                steps_reg <= idx_reg;
            end
            CMD_MLO: begin
                pp_reg <= mul_p[PP_W-1:0];
            end
            CMD_MHI: begin
                hp_reg <= mul_p[PP_W-1:0];
            end
            CMD_NORM: begin
                tmag_reg  <= new_mag;
                tneg_reg  <= (tneg_reg ^ dneg_reg) && (new_mag != '0);
                sat_reg   <= sat_reg | over;
                steps_reg <= steps_reg - idx_t'(1);
            end
            CMD_ACC: begin
                sum_reg <= sum_reg + term_s;
                idx_reg <= idx_reg + idx_t'(1);
            end
            CMD_FIN: begin
                if (clip_hi) begin
                    out_value_reg <= SUM_MAX[DATA_W-1:0];
                end else if (clip_lo) begin
                    out_value_reg <= SUM_MIN[DATA_W-1:0];
                end else begin
                    out_value_reg <= sum_reg[DATA_W-1:0];
                end
                out_status_reg <= sat_reg | clip_hi | clip_lo;
            end
            default: begin
            end
        endcase
    end

    // Status to the controller; a zero term stays zero
    assign status.term_done = (steps_reg == '0) || (tmag_reg == '0);
    assign status.last_term = (idx_reg == idx_t'(MAX_ORDER));

    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

endmodule

// ----- hw/rtl/taylor_series_evaluator_top.sv -----
// Top level of the Taylor series evaluator: controller plus datapath.
//
// Usage:
// - Input words on s_*: s_tuser selects write (0) or evaluate (1). A write stores
//   coeff_value as derivative coeff_index; an evaluate returns the truncated
//   series sum of d[i]/i! * (x - a)^i for x = eval_point, all signed Q16.16.
// - Every input word gives one output word on m_*: m_tdata is the series value,
//   m_tuser is set when a term or the final sum saturated. Writes return 0 / 0.
// - cfg_wr_en / cfg_wr_data set the expansion point a; write only while idle.
// - A write word shows on m_* in the cycle after acceptance. An evaluate runs,
//   for each order i, the coefficient step and k_i multiply-by-(x - a) steps,
//   where k_i <= i is the number of steps run before the term reaches zero, and
//   then adds the term. Each step uses the one shared 32x32 multiplier in turn
//   (low half, high half, recombine and clamp).
// - One word is in flight at a time; the next word is accepted when the block
//   is idle and the output register is empty or being emptied.
// - When m_tready is low the result waits in the output register and input
//   stalls after that single word.
// - Reset (aresetn low, synchronous) clears the derivative store and the
//   expansion point to zero and drops any pending output word.
module taylor_series_evaluator_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tse_pkg::DATA_W-1:0]    cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] coeff_index, [34:3] coeff_value, [66:35] eval_point, [71:67] zero
    input  logic [tse_pkg::SDATA_W-1:0]   s_tdata,
    // [0] command
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] series_value
    output logic [tse_pkg::DATA_W-1:0]    m_tdata,
    // [0] status
    output logic                          m_tuser
);
    import tse_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tse_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_data     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .status      (status),
        .out_value   (m_tdata),
        .out_status  (m_tuser)
    );

endmodule

// ----- bench/tse_series_checker.sv -----
// Checker for the Taylor series evaluator: tracks the store, predicts each series word and compares.
module tse_series_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [tse_pkg::DATA_W-1:0]   cfg_wr_data,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [tse_pkg::SDATA_W-1:0]  s_tdata,
    input  logic                         s_tuser,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [tse_pkg::DATA_W-1:0]   m_tdata,
    input  logic                         m_tuser,
    output int                           fail_count,
    output int                           pending
);
    import tse_pkg::*;

    // Term magnitude bound and the product bound past which a term clamps
    localparam logic [63:0] TERM_CAP = (64'd1 << 46) - 64'd1;
    localparam logic [63:0] PROD_CAP = (64'd1 << 62) - 64'd1;
    localparam longint      SUM_HI   = 64'sd2147483647;
    localparam longint      SUM_LO   = -64'sd2147483648;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              saturated;
    } series_word_t;

    logic [DATA_W-1:0] deriv_mem [DEPTH];
    logic [DATA_W-1:0] exp_point;
    series_word_t      expected_series_q [$];

    initial fail_count = 0;
    initial pending = 0;

    // round(2^32 / i!) as unsigned Q0.32, 0! and 1! both 1.0
    function automatic logic [63:0] inv_factorial(input int order);
        case (order)
            0:       return 64'd4294967296;
            1:       return 64'd4294967296;
            2:       return 64'd2147483648;
            3:       return 64'd715827883;
            4:       return 64'd178956971;
            5:       return 64'd35791394;
            6:       return 64'd5965232;
            7:       return 64'd852176;
            default: return 64'd0;
        endcase
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Sum of d[i]/i! * (x - a)^i with per-term clamp and final 32-bit saturation
    function automatic series_word_t predict_series_value(input logic [DATA_W-1:0] x);
        longint       delta;
        longint       sum;
        longint       term;
        longint       d;
        logic [63:0]  m;
        logic [63:0]  ud;
        logic [127:0] full;
        logic         sat;
        int           i;
        int           k;
        series_word_t res;
        delta = longint'($signed(x)) - longint'($signed(exp_point));
        ud = magnitude(delta);
        sum = 0;
        sat = 1'b0;
        for (i = 0; i < DEPTH; i++) begin
            d = longint'($signed(deriv_mem[i]));
            m = (magnitude(d) * inv_factorial(i)) >> 32;
            term = (d < 0) ? -longint'(m) : longint'(m);
            for (k = 0; k < i; k++) begin
                full = {64'd0, magnitude(term)} * {64'd0, ud};
                if (full > {64'd0, PROD_CAP}) begin
                    m = TERM_CAP;
                    sat = 1'b1;
                end else begin
                    m = full[79:16];
                end
                term = ((term < 0) != (delta < 0)) ? -longint'(m) : longint'(m);
            end
            sum += term;
        end
        if (sum > SUM_HI) begin
            sum = SUM_HI;
            sat = 1'b1;
        end else if (sum < SUM_LO) begin
            sum = SUM_LO;
            sat = 1'b1;
        end
        res.value = sum[DATA_W-1:0];
        res.saturated = sat;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("[tse_checker] %0t: %s got %h want %h", $time, what, got, want);
        fail_count++;
    endtask

    // Track config and store, queue predictions, compare output words
    always @(posedge aclk) begin
        series_word_t want;
        if (!aresetn) begin
            foreach (deriv_mem[j]) deriv_mem[j] = '0;
            exp_point = '0;
            expected_series_q.delete();
        end else begin
            if (cfg_wr_en) exp_point = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_WRITE) begin
                    deriv_mem[s_tdata[IDX_LSB +: IDX_W]] = s_tdata[COEFF_LSB +: DATA_W];
                    expected_series_q.push_back('{value: '0, saturated: 1'b0});
                end else begin
                    expected_series_q.push_back(
                        predict_series_value(s_tdata[POINT_LSB +: DATA_W]));
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_series_q.size() == 0) begin
                    report_mismatch("unexpected word, series_value", m_tdata, '0);
                end else begin
                    want = expected_series_q.pop_front();
                    if (m_tdata !== want.value)
                        report_mismatch("series_value", m_tdata, want.value);
                    if (m_tuser !== want.saturated)
                        report_mismatch("status", {31'd0, m_tuser}, {31'd0, want.saturated});
                end
            end
        end
        pending <= expected_series_q.size();
    end

endmodule

// ----- bench/tb_taylor_series_evaluator_top.sv -----
// Testbench top for the Taylor series evaluator: clock, reset, stimulus and verdict.
module tb_taylor_series_evaluator_top;
    import tse_pkg::*;

    localparam int CLK_HALF          = 4;
    localparam int RESET_CYCLES      = 8;
    localparam int CYCLE_LIMIT       = 1_000_000;
    localparam int ITEMS_PER_SETTING = 56;
    // covers the longest evaluate plus the output register
    localparam int DRAIN_CYCLES      = 110;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [DATA_W-1:0]  cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [SDATA_W-1:0] s_tdata     = '0;
    logic               s_tuser     = OP_WRITE;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [DATA_W-1:0]  m_tdata;
    logic               m_tuser;

    int                 fail_count;
    int                 pending;
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 cycle_count    = 0;
    logic [DATA_W-1:0]  point_a        = '0;

    always #CLK_HALF aclk = ~aclk;

    taylor_series_evaluator_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    tse_series_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Output side backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("taylor_series_evaluator_top: mismatch");
            $finish;
        end
    end

    // Mostly moderate Q16.16 values, some full-range and some extremes
    function automatic logic [DATA_W-1:0] rand_q16();
        logic [DATA_W-1:0] span;
        case ($urandom_range(7))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    3:       return 32'hffff_ffff;
                    default: return 32'h0001_0000;
                endcase
            end
            default: begin
                span = 32'd1 << (17 + $urandom_range(12));
                return ($urandom & (span - 1)) - (span >> 1);
            end
        endcase
    endfunction

    // Present one word after an optional random gap, return once accepted
    task automatic send_word(input logic cmd, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] coeff, input logic [DATA_W-1:0] point);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(SDATA_W - POINT_LSB - DATA_W){1'b0}}, point, coeff, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop sending and wait for every outstanding word
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic set_expansion_point(input logic [DATA_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        point_a = value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [DATA_W-1:0] span;
        logic [DATA_W-1:0] x;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty store, final clamps, term clamp cancelling, high orders
        send_word(OP_EVAL,  3'd0, $urandom, 32'h0000_0000);
        send_word(OP_WRITE, 3'd0, 32'h0001_0000, $urandom);
        send_word(OP_WRITE, 3'd1, 32'h7fff_ffff, $urandom);
        send_word(OP_EVAL,  3'd7, $urandom, 32'h7fff_ffff);
        send_word(OP_EVAL,  3'd7, $urandom, 32'h8000_0000);
        send_word(OP_WRITE, 3'd1, 32'h0000_0000, $urandom);
        send_word(OP_WRITE, 3'd2, 32'h7fff_ffff, $urandom);
        send_word(OP_WRITE, 3'd3, 32'h8000_0000, $urandom);
        send_word(OP_EVAL,  3'd0, $urandom, 32'h7fff_ffff);
        send_word(OP_WRITE, 3'd2, 32'h0000_0000, $urandom);
        send_word(OP_WRITE, 3'd3, 32'h0000_0000, $urandom);
        send_word(OP_WRITE, 3'd7, 32'h8000_0000, $urandom);
        send_word(OP_EVAL,  3'd0, $urandom, 32'h0002_0000);
        send_word(OP_EVAL,  3'd0, $urandom, 32'hfffe_0000);
        send_word(OP_WRITE, 3'd4, 32'hffff_ffff, $urandom);
        send_word(OP_WRITE, 3'd5, 32'h0000_0001, $urandom);
        send_word(OP_WRITE, 3'd6, 32'h0001_0000, $urandom);
        send_word(OP_EVAL,  3'd0, $urandom, 32'h0001_0000);
        send_word(OP_WRITE, 3'd0, 32'h8000_0000, $urandom);
        send_word(OP_WRITE, 3'd7, 32'h7fff_ffff, $urandom);
        send_word(OP_EVAL,  3'd0, $urandom, 32'h0000_0000);
        // widest negative and zero delta
        set_expansion_point(32'h7fff_ffff);
        send_word(OP_EVAL,  3'd0, $urandom, 32'h8000_0000);
        send_word(OP_EVAL,  3'd0, $urandom, 32'h7fff_ffff);
        // widest positive delta
        set_expansion_point(32'h8000_0000);
        send_word(OP_EVAL,  3'd0, $urandom, 32'h7fff_ffff);

        // Random: four idling profiles, two expansion points each
        for (int phase = 0; phase < 4; phase++) begin
            settle();
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            for (int setting = 0; setting < 2; setting++) begin
                case (phase * 2 + setting)
                    0:       set_expansion_point(32'h0000_0000);
                    3:       set_expansion_point(32'h8000_0000);
                    6:       set_expansion_point(32'h7fff_ffff);
                    default: set_expansion_point(rand_q16());
                endcase
                repeat (ITEMS_PER_SETTING) begin
                    if ($urandom_range(99) < 55) begin
                        send_word(OP_WRITE, IDX_W'($urandom_range(7)), rand_q16(), $urandom);
                    end else begin
                        // mostly close to the expansion point so terms stay meaningful
                        if ($urandom_range(99) < 60) begin
                            span = 32'd1 << (15 + $urandom_range(6));
                            x = point_a + ($urandom & (span - 1)) - (span >> 1);
                        end else begin
                            x = rand_q16();
                        end
                        send_word(OP_EVAL, IDX_W'($urandom_range(7)), $urandom, x);
                    end
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("taylor_series_evaluator_top: match");
        end else begin
            $display("taylor_series_evaluator_top: mismatch");
        end
        $finish;
    end

endmodule
